### rtl/tla_pkg.sv
// tla_pkg: shared types, constants and helpers of the toggle leakage accumulator
// used by the interfaces, controller, datapath and top level

package tla_pkg;

    localparam int SLOT_COUNT_DEF      = 1024;
    localparam int MAX_SIGNAL_BITS_DEF = 64;
    localparam int MAX_FILL_DEF        = 63;

    localparam int SLOT_W     = 10;
    localparam int BITS_W     = 7;
    localparam int STAMP_W    = 48;
    localparam int VALUE_W    = 64;
    localparam int LEAK_W     = 17;
    localparam int DS_W       = 32;
    localparam int INDEX_W    = STAMP_W + 1;
    localparam int DIV_CNT_W  = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [LEAK_W-1:0]    LEAK_MAX = 17'd65536;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd48;

    typedef enum logic [1:0] {
        CMD_DECLARE = 2'd0,
        CMD_STAMP   = 2'd1,
        CMD_CHANGE  = 2'd2,
        CMD_END     = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_LEAKAGE_MODEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWNSAMPLE    = 2'd2;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic decl_write;
        logic chg_read;
        logic chg_calc;
        logic chg_acc;
        logic div_step;
        logic eval;
        logic emit_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        cmd_t in_cmd;
        logic align;
        logic div_done;
        logic emit_done;
    } ctrl_status_t;

    function automatic logic [VALUE_W-1:0] width_mask(input logic [BITS_W-1:0] bits);
        logic [VALUE_W-1:0] m;
        if (bits >= 7'd64)
            m = '1;
        else
            m = (64'd1 << bits) - 64'd1;
        return m;
    endfunction

endpackage

### rtl/tla_item_if.sv
// tla_item_if: input word channel of the toggle leakage accumulator
// depends on tla_pkg for field widths

interface tla_item_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [tla_pkg::SLOT_W-1:0]    slot;
    logic [tla_pkg::BITS_W-1:0]    signal_bits;
    logic                          counted;
    logic [tla_pkg::STAMP_W-1:0]   stamp;
    logic [tla_pkg::VALUE_W-1:0]   new_value;
    logic [tla_pkg::BITS_W-1:0]    given_bits;

    modport source (output valid, command, slot, signal_bits, counted, stamp, new_value,
                    given_bits, input ready);
    modport sink (input valid, command, slot, signal_bits, counted, stamp, new_value,
                  given_bits, output ready);
endinterface

### rtl/tla_result_if.sv
// tla_result_if: leakage sample channel of the toggle leakage accumulator
// depends on tla_pkg for field widths

interface tla_result_if;
    logic                        valid;
    logic                        ready;
    logic [tla_pkg::LEAK_W-1:0]  leakage;
    logic                        last;
    logic                        gap_clipped;

    modport source (output valid, leakage, last, gap_clipped, input ready);
    modport sink (input valid, leakage, last, gap_clipped, output ready);
endinterface

### rtl/toggle_leakage_accumulator.sv
// toggle_leakage_accumulator: declare writes the slot; value change reads, updates and
// popcounts it (RD, CALC, ACC); time stamp or end of stream evaluates and then sends or
// drops one sample per step, held by output stalls; aligned stamps first run the 48-step
// stamp/downsample divider; one word in flight, output register frees the input side
// reset: all control cleared, then a clear pass over all SLOT_COUNT slots clears the values
// and declared flags while no word is taken; configuration writes are taken throughout

module toggle_leakage_accumulator #(
    parameter int SLOT_COUNT      = tla_pkg::SLOT_COUNT_DEF,
    parameter int MAX_SIGNAL_BITS = tla_pkg::MAX_SIGNAL_BITS_DEF,
    parameter int MAX_FILL        = tla_pkg::MAX_FILL_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tla_item_if.sink                       item,
    tla_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [tla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tla_pkg::DS_W-1:0]       cfg_data
);

    tla_pkg::ctrl_cmd_t    cmd;
    tla_pkg::ctrl_status_t status;

    tla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    tla_datapath #(
        .SLOT_COUNT      (SLOT_COUNT),
        .MAX_SIGNAL_BITS (MAX_SIGNAL_BITS),
        .MAX_FILL        (MAX_FILL)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .command     (item.command),
        .slot        (item.slot),
        .signal_bits (item.signal_bits),
        .counted     (item.counted),
        .stamp       (item.stamp),
        .new_value   (item.new_value),
        .given_bits  (item.given_bits),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_leakage (result.leakage),
        .out_last    (result.last),
        .out_clipped (result.gap_clipped)
    );

endmodule

### rtl/tla_ctrl.sv
// tla_ctrl: sequencing state machine of the toggle leakage accumulator
// depends on tla_pkg for command and status structs

module tla_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  tla_pkg::ctrl_status_t status,
    output tla_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECL,
        S_RD,
        S_CALC,
        S_ACC,
        S_DIV,
        S_EVAL,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (status.in_cmd)
                        tla_pkg::CMD_DECLARE: state_next = S_DECL;
                        tla_pkg::CMD_CHANGE:  state_next = S_RD;
                        tla_pkg::CMD_STAMP:   state_next = status.align ? S_DIV : S_EVAL;
                        tla_pkg::CMD_END:     state_next = S_EVAL;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_DECL:
            begin
                cmd.decl_write = 1'b1;
                state_next     = S_IDLE;
            end
            S_RD:
            begin
                cmd.chg_read = 1'b1;
                state_next   = S_CALC;
            end
            S_CALC:
            begin
                cmd.chg_calc = 1'b1;
                state_next   = S_ACC;
            end
            S_ACC:
            begin
                cmd.chg_acc = 1'b1;
                state_next  = S_IDLE;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_EVAL;
                else
                    cmd.div_step = 1'b1;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (status.emit_done)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### rtl/tla_datapath.sv
// tla_datapath: slot memories, accumulator, divider, sample emitter and output register
// depends on tla_pkg; driven by tla_ctrl commands

module tla_datapath #(
    parameter int SLOT_COUNT      = tla_pkg::SLOT_COUNT_DEF,
    parameter int MAX_SIGNAL_BITS = tla_pkg::MAX_SIGNAL_BITS_DEF,
    parameter int MAX_FILL        = tla_pkg::MAX_FILL_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tla_pkg::ctrl_cmd_t              cmd,
    output tla_pkg::ctrl_status_t           status,
    input  logic [1:0]                      command,
    input  logic [tla_pkg::SLOT_W-1:0]      slot,
    input  logic [tla_pkg::BITS_W-1:0]      signal_bits,
    input  logic                            counted,
    input  logic [tla_pkg::STAMP_W-1:0]     stamp,
    input  logic [tla_pkg::VALUE_W-1:0]     new_value,
    input  logic [tla_pkg::BITS_W-1:0]      given_bits,
    input  logic                            cfg_we,
    input  logic [tla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tla_pkg::DS_W-1:0]        cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tla_pkg::LEAK_W-1:0]      out_leakage,
    output logic                            out_last,
    output logic                            out_clipped
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int VW = MAX_SIGNAL_BITS;
    localparam int LW = tla_pkg::LEAK_W;
    localparam int IW = tla_pkg::INDEX_W;

    // slot stores
    logic [VW-1:0]                  val_mem  [SLOT_COUNT];
    logic [1:0]                     flag_mem [SLOT_COUNT];
    logic [tla_pkg::BITS_W-1:0]     wid_mem  [SLOT_COUNT];

    // configuration
    logic                           model_reg;
    logic                           align_reg;
    logic [tla_pkg::DS_W-1:0]       ds_reg;

    // captured word
    tla_pkg::cmd_t                  cmd_reg;
    logic [AW-1:0]                  addr_reg;
    logic                           in_range_reg;
    logic [tla_pkg::BITS_W-1:0]     sbits_reg;
    logic                           counted_reg;
    logic [tla_pkg::VALUE_W-1:0]    newv_reg;
    logic [tla_pkg::BITS_W-1:0]     given_reg;

    logic [AW-1:0]                  clr_cnt_reg;
    logic [VW-1:0]                  rd_val_reg;
    logic [1:0]                     rd_flag_reg;
    logic [tla_pkg::BITS_W-1:0]     rd_wid_reg;
    logic [VW-1:0]                  rise_reg;
    logic [VW-1:0]                  fall_reg;
    logic                           act_reg;

    logic [LW-1:0]                  run_reg;
    logic signed [IW-1:0]           prev_reg;
    logic [1:0]                     drop_reg;

    logic [tla_pkg::STAMP_W-1:0]    quo_reg;
    logic [tla_pkg::DS_W-1:0]       rem_reg;
    logic [tla_pkg::DIV_CNT_W-1:0]  div_cnt_reg;

    logic [LW-1:0]                  samp_reg;
    logic                           clip_reg;
    logic [tla_pkg::BITS_W-1:0]     left_reg;

    logic                           out_valid_reg;
    logic [LW-1:0]                  out_leak_reg;
    logic                           out_last_reg;
    logic                           out_clip_reg;

    logic [VW-1:0]                  nv;
    logic [tla_pkg::DS_W-1:0]       ds_eff;
    logic [tla_pkg::DS_W:0]         trial;
    logic                           trial_ge;
    logic [tla_pkg::BITS_W-1:0]     pop_rise;
    logic [tla_pkg::BITS_W-1:0]     pop_fall;
    logic signed [LW+1:0]           sum;
    logic [LW-1:0]                  sum_sat;
    logic signed [IW:0]             diff;
    logic [tla_pkg::BITS_W-1:0]     fill;
    logic                           fill_clip;
    logic                           main_hit;
    logic                           out_free;
    logic [1:0]                     drop_load;

    assign out_free  = !out_valid_reg || out_ready;
    assign drop_load = model_reg ? 2'd1 : 2'd2;

    assign nv = VW'(newv_reg & tla_pkg::width_mask(given_reg)
                    & tla_pkg::width_mask(rd_wid_reg));

    assign ds_eff   = (ds_reg == '0) ? 32'd1 : ds_reg;
    assign trial    = {rem_reg, quo_reg[tla_pkg::STAMP_W-1]};
    assign trial_ge = (trial >= {1'b0, ds_eff});

    always_comb
    begin
        pop_rise = tla_pkg::BITS_W'($countones(rise_reg));
        pop_fall = tla_pkg::BITS_W'($countones(fall_reg));
        if (model_reg)
            sum = $signed({2'b00, run_reg}) + $signed({12'd0, pop_rise})
                  - $signed({12'd0, pop_fall});
        else
            sum = $signed({2'b00, run_reg}) + $signed({12'd0, pop_rise})
                  + $signed({12'd0, pop_fall});
        priority if (sum < 0)
            sum_sat = '0;
        else if (sum > $signed({2'b00, tla_pkg::LEAK_MAX}))
            sum_sat = tla_pkg::LEAK_MAX;
        else
            sum_sat = LW'(sum);
    end

    // index step against the previous index decides fill copies
    always_comb
    begin
        diff      = $signed({2'b00, quo_reg}) - $signed({prev_reg[IW-1], prev_reg});
        fill_clip = 1'b0;
        priority if (diff > $signed((IW+1)'(MAX_FILL + 1)))
        begin
            fill      = tla_pkg::BITS_W'(MAX_FILL);
            fill_clip = 1'b1;
        end
        else if (diff >= $signed((IW+1)'(2)))
            fill = tla_pkg::BITS_W'(diff - 1);
        else
            fill = '0;
        main_hit = (diff != '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            val_mem[clr_cnt_reg]  <= '0;
            flag_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.decl_write && in_range_reg)
        begin
            val_mem[addr_reg]  <= '0;
            flag_mem[addr_reg] <= {1'b1, counted_reg};
            wid_mem[addr_reg]  <= (sbits_reg > tla_pkg::BITS_W'(MAX_SIGNAL_BITS))
                                  ? tla_pkg::BITS_W'(MAX_SIGNAL_BITS) : sbits_reg;
        end
        else if (cmd.chg_calc && in_range_reg && rd_flag_reg[1])
        begin
            val_mem[addr_reg] <= nv;
        end
        if (cmd.chg_read)
        begin
            rd_val_reg  <= val_mem[addr_reg];
            rd_flag_reg <= flag_mem[addr_reg];
            rd_wid_reg  <= wid_mem[addr_reg];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg     <= AW'(slot);
            in_range_reg <= (32'(slot) < 32'(SLOT_COUNT));
            sbits_reg    <= signal_bits;
            counted_reg  <= counted;
            newv_reg     <= new_value;
            given_reg    <= given_bits;
        end
        if (cmd.chg_calc)
        begin
            rise_reg <= nv & ~rd_val_reg;
            fall_reg <= rd_val_reg & ~nv;
        end
        if (cmd.capture)
        begin
            quo_reg <= stamp;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[tla_pkg::STAMP_W-2:0], trial_ge};
            rem_reg <= trial_ge ? tla_pkg::DS_W'(trial - {1'b0, ds_eff})
                                : tla_pkg::DS_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg     <= 1'b0;
            align_reg     <= 1'b0;
            ds_reg        <= 32'd1;
            cmd_reg       <= tla_pkg::CMD_DECLARE;
            clr_cnt_reg   <= '0;
            act_reg       <= 1'b0;
            run_reg       <= '0;
            prev_reg      <= '1;
            drop_reg      <= 2'd2;
            div_cnt_reg   <= '0;
            samp_reg      <= '0;
            clip_reg      <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_leak_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_clip_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tla_pkg::REG_LEAKAGE_MODEL:
                    begin
                        model_reg <= cfg_data[0];
                        drop_reg  <= cfg_data[0] ? 2'd1 : 2'd2;
                    end
                    tla_pkg::REG_ALIGN_MODE: align_reg <= cfg_data[0];
                    tla_pkg::REG_DOWNSAMPLE: ds_reg    <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;

            if (cmd.capture)
            begin
                cmd_reg     <= tla_pkg::cmd_t'(command);
                div_cnt_reg <= tla_pkg::DIV_STEPS;
            end
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - 1'b1;

            if (cmd.chg_calc)
                act_reg <= in_range_reg && rd_flag_reg[1] && rd_flag_reg[0];

            if (cmd.chg_acc && act_reg)
                run_reg <= sum_sat;

            // a word leaving while the next one loads keeps valid high
            if (out_valid_reg && out_ready
                && !(cmd.emit_step && left_reg != '0 && drop_reg == '0))
                out_valid_reg <= 1'b0;

            if (cmd.eval)
            begin
                samp_reg <= run_reg;
                if (cmd_reg == tla_pkg::CMD_END)
                begin
                    clip_reg <= 1'b0;
                    left_reg <= align_reg ? 7'd0 : 7'd1;
                    run_reg  <= '0;
                    prev_reg <= '1;
                end
                else if (align_reg)
                begin
                    clip_reg <= fill_clip;
                    left_reg <= fill + {6'd0, main_hit};
                    if (main_hit)
                    begin
                        prev_reg <= $signed({1'b0, quo_reg});
                        if (!model_reg)
                            run_reg <= '0;
                    end
                end
                else
                begin
                    clip_reg <= 1'b0;
                    left_reg <= 7'd1;
                    if (!model_reg)
                        run_reg <= '0;
                end
            end

            if (cmd.emit_step)
            begin
                if (left_reg == '0)
                begin
                    if (cmd_reg == tla_pkg::CMD_END)
                        drop_reg <= drop_load;
                end
                else if (drop_reg != '0)
                begin
                    drop_reg <= drop_reg - 1'b1;
                    left_reg <= left_reg - 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                    out_leak_reg  <= samp_reg;
                    out_last_reg  <= (left_reg == 7'd1);
                    out_clip_reg  <= clip_reg;
                    left_reg      <= left_reg - 1'b1;
                end
            end
        end
    end

    assign status.clear_done = (clr_cnt_reg == AW'(SLOT_COUNT - 1));
    assign status.in_cmd     = tla_pkg::cmd_t'(command);
    assign status.align      = align_reg;
    assign status.div_done   = (div_cnt_reg == '0);
    assign status.emit_done  = (left_reg == '0);

    assign out_valid   = out_valid_reg;
    assign out_leakage = out_leak_reg;
    assign out_last    = out_last_reg;
    assign out_clipped = out_clip_reg;

endmodule

### rtl/tla_checker.sv
// tla_checker: port-level assertions for the toggle leakage accumulator
// depends on tla_pkg; bound to toggle_leakage_accumulator below

module tla_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [tla_pkg::LEAK_W-1:0]  result_leakage,
    input logic                        result_last,
    input logic                        result_gap_clipped
);

    // a stalled word keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_leakage)
            && $stable(result_last) && $stable(result_gap_clipped))
        else $error("result word changed while stalled");

    a_leak_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_leakage <= tla_pkg::LEAK_MAX)
        else $error("leakage above saturation limit");

    // input ready drops after every accepted word
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("input ready right after accept");

    a_no_ready_in_reset: assert property (@(posedge clk)
        !rst_n |-> !item_ready && !result_valid)
        else $error("handshake active during reset");

endmodule

bind toggle_leakage_accumulator tla_checker u_tla_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_leakage     (result.leakage),
    .result_last        (result.last),
    .result_gap_clipped (result.gap_clipped)
);
